// File: hdl/gdc_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date counter.
package gdc_pkg;

    // Default year register width and calendar constants
    localparam int unsigned YEAR_BITS_DEF = 16;
    localparam int unsigned RESET_YEAR    = 1988;
    localparam logic [4:0]  CLAMP_DAY     = 5'd28;
    localparam logic [3:0]  LAST_MONTH    = 4'd12;
    localparam int unsigned LEAP_DIV      = 25;   // 400 = 16 * 25, 100 = 4 * 25

    // Request codes
    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_ADVANCE = 2'd1,
        REQ_COUNT   = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CLAMP = 2'd2,
        ST_WRAP  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CHECK = 2'd1,
        S_WALK  = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    // Input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  day_in;
        logic [3:0]  month_in;
        logic [15:0] year_in;
        logic [15:0] day_count;
    } t_in;

    // Result item
    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [15:0] year_out;
        logic        leap_year;
        logic [1:0]  status;
        logic [31:0] days_between;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic step;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ready;      // leap flags of current and target year are up to date
        logic need_walk;  // request needs the day walk
        logic walk_done;  // walk has reached its end
        logic out_free;   // result register can take a new result
    } t_stat;

    // Days in month m; out-of-range months give 31
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Multiplicative inverse of an odd number modulo 2^64 (Newton iteration)
    function automatic logic [63:0] odd_inverse(input logic [63:0] a);
        logic [63:0] x;
        x = a;
        for (int i = 0; i < 6; i++) begin
            x = x * (64'd2 - a * x);
        end
        return x;
    endfunction

endpackage

// File: hdl/gdc_leap.sv
// Two-stage leap-year evaluator with a freshness flag for the year it watches.
module gdc_leap #(
    parameter int unsigned YEAR_BITS = gdc_pkg::YEAR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [YEAR_BITS-1:0] i_year,
    output logic                 o_leap,
    output logic                 o_ok
);
    import gdc_pkg::*;

    // y is a multiple of 25 exactly when y * inv(25) mod 2^N <= (2^N - 1) / 25
    localparam logic [YEAR_BITS-1:0] INV25 = YEAR_BITS'(odd_inverse(64'(LEAP_DIV)));
    localparam logic [YEAR_BITS-1:0] LIM25 =
        YEAR_BITS'(((64'd1 << YEAR_BITS) - 64'd1) / LEAP_DIV);

    logic [YEAR_BITS-1:0] r_tag1;
    logic [YEAR_BITS-1:0] r_prod;
    logic [YEAR_BITS-1:0] r_tag2;
    logic                 r_leap;
    logic                 r_v1;
    logic                 r_v2;
    logic                 n_leap;

    // Stage 1: modular product
    always_ff @(posedge i_clk) begin
        r_tag1 <= i_year;
        r_prod <= YEAR_BITS'(i_year * INV25);
    end

    // Stage 2: divisible by 4, and by 16 where also divisible by 25
    assign n_leap = (r_tag1[1:0] == 2'b00) && ((r_prod > LIM25) || (r_tag1[3:0] == 4'd0));

    always_ff @(posedge i_clk) begin
        r_tag2 <= r_tag1;
        r_leap <= n_leap;
    end

    // Pipeline fill after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= 1'b1;
            r_v2 <= r_v1;
        end
    end

    assign o_leap = r_leap;
    assign o_ok   = r_v2 && (r_tag2 == i_year);

endmodule

// File: hdl/gdc_datapath.sv
// Date registers, request checks, one-day stepper and result register.
module gdc_datapath #(
    parameter int unsigned YEAR_BITS = gdc_pkg::YEAR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gdc_pkg::t_in  i_in_data,
    input  gdc_pkg::t_cmd i_cmd,
    output gdc_pkg::t_stat o_stat,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gdc_pkg::t_out o_out_data
);
    import gdc_pkg::*;

    // Current date
    logic [4:0]           r_day;
    logic [3:0]           r_month;
    logic [YEAR_BITS-1:0] r_year;
    // Captured request
    t_req                 r_req;
    logic [5:0]           r_td;
    logic [3:0]           r_tm;
    logic [YEAR_BITS-1:0] r_ty;
    logic [15:0]          r_cnt;
    logic [31:0]          r_between;
    t_status              r_status;
    // Result register
    logic                 r_out_valid;
    t_out                 r_out;

    logic                 leap_cur;
    logic                 ok_cur;
    logic                 leap_tgt;
    logic                 ok_tgt;
    logic                 tgt_bad;
    logic                 tgt_long;
    logic                 tgt_later;
    logic                 at_target;
    logic                 month_end;
    logic [YEAR_BITS-1:0] year_inc;

    gdc_leap #(.YEAR_BITS(YEAR_BITS)) u_leap_cur (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_year  (r_year),
        .o_leap  (leap_cur),
        .o_ok    (ok_cur)
    );

    gdc_leap #(.YEAR_BITS(YEAR_BITS)) u_leap_tgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_year  (r_ty),
        .o_leap  (leap_tgt),
        .o_ok    (ok_tgt)
    );

    // Checks on the captured date
    assign tgt_bad  = (r_td == 6'd0) || r_td[5] || (r_tm == 4'd0) || (r_tm > LAST_MONTH)
                      || (r_ty == '0);
    assign tgt_long = r_td > {1'b0, month_len(r_tm, leap_tgt)};

    // Order of target against current date
    assign at_target = (r_ty == r_year) && (r_tm == r_month) && (r_td == {1'b0, r_day});
    assign tgt_later = (r_ty > r_year)
                     || ((r_ty == r_year) && (r_tm > r_month))
                     || ((r_ty == r_year) && (r_tm == r_month) && (r_td > {1'b0, r_day}));

    // One-day step
    assign month_end = r_day >= month_len(r_month, leap_cur);
    assign year_inc  = r_year + YEAR_BITS'(1);

    // Status to the controller
    always_comb begin
        o_stat.ready     = ok_cur && ok_tgt;
        o_stat.need_walk = ((r_req == REQ_ADVANCE) && (r_cnt != 16'd0))
                         || ((r_req == REQ_COUNT) && !tgt_bad && !tgt_long && tgt_later);
        o_stat.walk_done = (r_req == REQ_ADVANCE) ? (r_cnt == 16'd0) : at_target;
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    // Current date: load, walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= 5'd1;
            r_month <= 4'd1;
            r_year  <= YEAR_BITS'(RESET_YEAR);
        end else if (i_cmd.decide && (r_req == REQ_LOAD)) begin
            r_year <= r_ty;
            if (tgt_bad) begin
                r_day   <= 5'd1;
                r_month <= 4'd1;
            end else if (tgt_long) begin
                r_day   <= CLAMP_DAY;
                r_month <= r_tm;
            end else begin
                r_day   <= r_td[4:0];
                r_month <= r_tm;
            end
        end else if (i_cmd.step) begin
            if (!month_end) begin
                r_day <= r_day + 5'd1;
            end else begin
                r_day <= 5'd1;
                if (r_month >= LAST_MONTH) begin
                    r_month <= 4'd1;
                    r_year  <= year_inc;
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end
        end
    end

    // Captured request, counters and status
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req     <= t_req'(i_in_data.req_type);
            r_td      <= i_in_data.day_in;
            r_tm      <= i_in_data.month_in;
            r_ty      <= YEAR_BITS'(i_in_data.year_in);
            r_cnt     <= i_in_data.day_count;
            r_between <= 32'd0;
            r_status  <= ST_OK;
        end else if (i_cmd.decide) begin
            case (r_req)
                REQ_LOAD: begin
                    if (tgt_bad) begin
                        r_status <= ST_RANGE;
                    end else if (tgt_long) begin
                        r_status <= ST_CLAMP;
                    end
                end
                REQ_COUNT: begin
                    if (tgt_bad || tgt_long) begin
                        r_status <= ST_RANGE;
                    end
                end
                default: begin
                    r_status <= r_status;
                end
            endcase
        end else if (i_cmd.step) begin
            if (r_req == REQ_ADVANCE) begin
                r_cnt <= r_cnt - 16'd1;
                // year rolled over to zero
                if (month_end && (r_month >= LAST_MONTH) && (year_inc == '0)) begin
                    r_status <= ST_WRAP;
                end
            end else if (r_between != '1) begin
                r_between <= r_between + 32'd1;
            end
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.day_out      <= r_day;
            r_out.month_out    <= r_month;
            r_out.year_out     <= 16'(r_year);
            r_out.leap_year    <= leap_cur;
            r_out.status       <= r_status;
            r_out.days_between <= r_between;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/gdc_ctrl.sv
// Request sequencer: capture, check, day walk and result hand-off.
module gdc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  gdc_pkg::t_stat i_stat,
    output gdc_pkg::t_cmd  o_cmd
);
    import gdc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.ready) n_state = i_stat.need_walk ? S_WALK : S_DONE;
            end
            S_WALK: begin
                if (i_stat.walk_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.ready && i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.decide = i_stat.ready;
            end
            S_WALK: begin
                // hold while the leap flag catches up after a new year
                o_cmd.step = !i_stat.walk_done && i_stat.ready;
            end
            S_DONE: begin
                o_cmd.emit = i_stat.ready && i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/gregorian_date_counter.sv
// Top level of the Gregorian date counter: sequencer plus date datapath.
//
// Keeps one Gregorian date (4/100/400 leap rule) and gives one result per
// request. Only one request is in flight: the input is stalled from the
// transfer until its result has been written to the output register, which
// then waits for the downstream side while the next request is taken. A
// rejected count, an earlier or equal target, an advance by zero and the
// unused request code go straight from the check to the result; a load also
// does, but its new year has to pass through the leap-year unit first. An
// advance walks day_count days and a count walks the days to the target: the
// datapath steps the date one day per cycle, pausing after each step into a
// new year while the pipelined leap-year unit re-evaluates the year. The
// check of a request is shorter when it repeats the year of the previous
// request. The sequencer returns to idle as the result is written, so the
// next request can be taken in the following cycle. Day counts saturate at
// 2^32 - 1. YEAR_BITS (12 to 32) sets the width of the internal year; the
// year ports stay 16 bits.
module gregorian_date_counter #(
    parameter int unsigned YEAR_BITS = gdc_pkg::YEAR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gdc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output gdc_pkg::t_out o_out_data
);
    import gdc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gdc_datapath #(.YEAR_BITS(YEAR_BITS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
